@@ rtl/core/nss_pkg.sv @@
// Shared types and constants for the NCO sawtooth/sine generator.
// Used by the front end, the queue, the back end and the top level.
package nss_pkg;

  localparam logic [1:0] MODE_SAW  = 2'd0;
  localparam logic [1:0] MODE_SINE = 2'd1;
  localparam logic [1:0] MODE_PASS = 2'd2;

  localparam int unsigned PHASE_BITS  = 32;
  localparam int unsigned SAMPLE_BITS = 16;

  // Register indexes on the configuration port.
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_FREQ = 1'b1;

  localparam logic [31:0] FREQ_RESET = 32'd8947848;

  // One frame handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]                    mode;
    logic [PHASE_BITS-1:0]         phase;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } nss_entry_t;

endpackage

@@ rtl/core/nss_front.sv @@
// Front end: configuration registers, phase accumulator and input acceptance.
// Depends on nss_pkg; feeds nss_queue.
module nss_front
  import nss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // left_in [15:0], right_in [31:16]
  input  logic        s_axis_tlast,  // buffer_end_in
  // Queue write side
  input  logic        q_full,
  output logic        q_push,
  output nss_entry_t  q_wdata
);

  logic [1:0]            mode;
  logic [31:0]           freq;
  logic [PHASE_BITS-1:0] phase;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {30'd0, mode};
      default:  prdata = freq;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SAW;
      freq <= FREQ_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        mode <= pwdata[1:0];
      end else begin
        freq <= pwdata;
      end
    end
  end

  assign s_axis_tready = ~q_full;
  assign q_push        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    q_wdata.mode  = mode;
    q_wdata.phase = phase;
    q_wdata.left  = s_axis_tdata[15:0];
    q_wdata.right = s_axis_tdata[31:16];
    q_wdata.last  = s_axis_tlast;
  end

  // Passthrough frames leave the oscillator where it is.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (q_push && mode != MODE_PASS) begin
      phase <= phase + freq;
    end
  end

endmodule

@@ rtl/core/nss_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on nss_pkg for the entry type.
module nss_queue
  import nss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  nss_entry_t wdata,
  input  logic       pop,
  output nss_entry_t rdata,
  output logic       full,
  output logic       empty
);

  nss_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/nss_rom.sv @@
// Sine ROM with two registered read ports, contents built at elaboration.
// Standalone; used by nss_back.
module nss_rom #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ADDR_BITS-1:0]    addr_a,
  input  logic [ADDR_BITS-1:0]    addr_b,
  output logic signed [15:0]      data_a,
  output logic signed [15:0]      data_b
);

  localparam int unsigned DEPTH = 2 ** ADDR_BITS;
  localparam logic [63:0] Q60_PI = 64'h3243F6A8885A308D;

  typedef logic [15:0] rom_t [DEPTH];

  function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d,
                                        input int unsigned nbits);
    logic [127:0] q;
    logic [127:0] r;
    int           j;
    q = '0;
    r = '0;
    for (j = int'(nbits) - 1; j >= 0; j--) begin
      r = {r[126:0], n[j]};
      if (r >= d) begin
        r    = r - d;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // (a*b) >> 60 in Q60 fixed point.
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [15:0] sine_entry(input int unsigned i);
    logic [127:0] den;
    logic [127:0] num;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  pos;
    logic [63:0]  sub;
    logic [63:0]  s;
    logic [63:0]  t;
    logic [63:0]  mag;
    logic         neg;
    int           k;
    den = 128'd10000 << ADDR_BITS;
    num = 128'(i) * 128'd62832;
    x   = 64'(udiv(num << 60, den, 100));
    neg = 1'b0;
    for (k = 0; k < 3; k++) begin
      if (x >= Q60_PI) begin
        x   = x - Q60_PI;
        neg = ~neg;
      end
    end
    if (x > (Q60_PI >> 1)) begin
      x = Q60_PI - x;
    end
    x2   = q60_mul(x, x);
    term = x;
    pos  = x;
    sub  = '0;
    for (k = 1; k <= 12; k++) begin
      term = 64'(udiv({64'd0, q60_mul(term, x2)}, 128'((2 * k) * (2 * k + 1)), 64));
      if (k % 2 == 1) begin
        sub = sub + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos > sub) ? pos - sub : 64'd0;
    t = (s >> 15) * 64'd32767;
    if (!neg) begin
      mag = (t + (64'd1 << 44)) >> 45;
      return mag[15:0];
    end
    mag = (t + (64'd1 << 44) - 64'd1) >> 45;
    return 16'(64'd0 - mag);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    int   i;
    for (i = 0; i < int'(DEPTH); i++) begin
      r[i] = sine_entry(i);
    end
    return r;
  endfunction

  localparam rom_t ROM_INIT = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= ROM_INIT[addr_a];
      data_b <= ROM_INIT[addr_b];
    end
  end

endmodule

@@ rtl/core/nss_back.sv @@
// Back end: ROM lookup, interpolation multiply and output register.
// Depends on nss_pkg and nss_rom; reads from nss_queue.
module nss_back
  import nss_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned FRACTION_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  nss_entry_t  q_rdata,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // left_out [15:0], right_out [31:16]
  output logic        m_axis_tlast   // buffer_end_out
);

  localparam int unsigned PROD_BITS = SAMPLE_BITS + FRACTION_BITS + 1;
  localparam int unsigned SUM_BITS  = PROD_BITS + 1;

  logic                        en;
  logic [TABLE_ADDR_BITS-1:0]  addr_a;
  logic [TABLE_ADDR_BITS-1:0]  addr_b;
  logic signed [15:0]          rom_a;
  logic signed [15:0]          rom_b;

  // Stage 1: table lookup in flight.
  logic                        s1_valid;
  logic [1:0]                  s1_mode;
  logic [FRACTION_BITS-1:0]    s1_frac;
  logic [15:0]                 s1_saw;
  logic [15:0]                 s1_left;
  logic [15:0]                 s1_right;
  logic                        s1_last;

  // Stage 2: weighted products.
  logic                        s2_valid;
  logic [1:0]                  s2_mode;
  logic signed [PROD_BITS-1:0] s2_prod_a;
  logic signed [PROD_BITS-1:0] s2_prod_b;
  logic [15:0]                 s2_saw;
  logic [15:0]                 s2_left;
  logic [15:0]                 s2_right;
  logic                        s2_last;

  logic signed [SUM_BITS-1:0]  sum;
  logic signed [SUM_BITS-1:0]  sum_shifted;
  logic [15:0]                 wave;
  logic [15:0]                 left_next;
  logic [15:0]                 right_next;

  // The whole pipe advances together whenever the output register can move.
  assign en    = ~m_axis_tvalid | m_axis_tready;
  assign q_pop = en & ~q_empty;

  assign addr_a = q_rdata.phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign addr_b = addr_a + TABLE_ADDR_BITS'(1);

  nss_rom #(
    .ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (en),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid      <= ~q_empty;
      s2_valid      <= s1_valid;
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode  <= q_rdata.mode;
      s1_frac  <= q_rdata.phase[PHASE_BITS-1-TABLE_ADDR_BITS -: FRACTION_BITS];
      s1_saw   <= q_rdata.phase[PHASE_BITS-1 -: SAMPLE_BITS];
      s1_left  <= q_rdata.left;
      s1_right <= q_rdata.right;
      s1_last  <= q_rdata.last;

      // The weight of entry a is the all-ones fraction minus f, which is ~f.
      s2_prod_b <= PROD_BITS'(rom_b) * PROD_BITS'($signed({1'b0, s1_frac}));
      s2_prod_a <= PROD_BITS'(rom_a) * PROD_BITS'($signed({1'b0, ~s1_frac}));
      s2_mode   <= s1_mode;
      s2_saw    <= s1_saw;
      s2_left   <= s1_left;
      s2_right  <= s1_right;
      s2_last   <= s1_last;

      m_axis_tdata <= {right_next, left_next};
      m_axis_tlast <= s2_last;
    end
  end

  always_comb begin
    sum         = SUM_BITS'(s2_prod_a) + SUM_BITS'(s2_prod_b);
    sum_shifted = sum >>> FRACTION_BITS;
    case (s2_mode)
      MODE_SAW: wave = s2_saw;
      default:  wave = sum_shifted[15:0];
    endcase
    case (s2_mode)
      MODE_PASS: begin
        left_next  = s2_left;
        right_next = s2_right;
      end
      default: begin
        left_next  = wave;
        right_next = 16'd0 - wave;
      end
    endcase
  end

endmodule

@@ rtl/core/nco_saw_sine_generator.sv @@
// Top level of the stereo NCO test-tone generator.
// Depends on nss_pkg, nss_front, nss_queue and nss_back.
//
// One stereo frame enters on the input stream and one frame leaves on the
// output stream, at a sustained rate of one frame per clock cycle while the
// output is not stalled; a frame passes through the queue slot, stage 1 (the
// ROM read), stage 2 and the output register before it is presented.
// The rate is set by the phase accumulator update in the front end and by
// the two-port sine ROM in the back end, which looks up both interpolation
// neighbors in the same cycle. A two-entry queue sits between front and back
// so that input and output stall independently.
// Register 0 (byte address 0) selects sawtooth, sine or passthrough;
// register 1 (byte address 4) is the signed phase increment per frame.
// Write registers only while no frames are in flight.
module nco_saw_sine_generator
  import nss_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned FRACTION_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // left_in [15:0], right_in [31:16]
  input  logic        s_axis_tlast,  // buffer_end_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // left_out [15:0], right_out [31:16]
  output logic        m_axis_tlast   // buffer_end_out
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  nss_entry_t q_wdata;
  nss_entry_t q_rdata;

  nss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  nss_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  nss_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/core/nss_checker.sv @@
// Port-level checker for nco_saw_sine_generator, with its bind statement.
// Sees only the top-level ports.
module nss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Frames accepted but not yet delivered: queue plus three pipeline stages.
  localparam logic [3:0] MAX_IN_FLIGHT = 4'd5;

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] in_flight;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 4'd0;
    end else begin
      in_flight <= in_flight + {3'd0, in_xfer} - {3'd0, out_xfer};
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !(out_xfer && in_flight == 4'd0 && !in_xfer))
    else $error("output transaction without a pending input frame");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    in_flight <= MAX_IN_FLIGHT)
    else $error("more frames in flight than the design can hold");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind nco_saw_sine_generator nss_checker u_nss_checker (.*);
